// ----- design/mm4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned ROW_W     = 2;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_MULT  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [ROW_W-1:0]         row_index;
    logic signed [ELEM_W-1:0] elem0;
    logic signed [ELEM_W-1:0] elem1;
    logic signed [ELEM_W-1:0] elem2;
    logic signed [ELEM_W-1:0] elem3;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic signed [ELEM_W-1:0] prod0;
    logic signed [ELEM_W-1:0] prod1;
    logic signed [ELEM_W-1:0] prod2;
    logic signed [ELEM_W-1:0] prod3;
    logic                     saturated;
  } out_item_t;

endpackage

// ----- design/mm4_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_if
// Valid/ready stream interfaces for input rows and product rows.
// ----------------------------------------------------------------------------
interface mm4_in_if;
  logic               valid;
  logic               ready;
  mm4_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mm4_out_if;
  logic               valid;
  logic               ready;
  mm4_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mm4_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_lane
// One product column: four split multiplies, product assembly and the
// exact dot-product sum, in three register stages.
// ----------------------------------------------------------------------------
module mm4_lane #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [DATA_WIDTH-1:0]      a_i [4],
  input  logic signed [DATA_WIDTH-1:0]      b_i [4],
  output logic signed [2*DATA_WIDTH+1:0]    sum_o
);

  localparam int unsigned LW = DATA_WIDTH / 2;
  localparam int unsigned HW = DATA_WIDTH - LW;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned SW = PW + 2;

  logic signed [2*HW-1:0]  pp_hh_d [4];
  logic signed [2*HW-1:0]  pp_hh_q [4];
  logic signed [HW+LW:0]   pp_hl_d [4];
  logic signed [HW+LW:0]   pp_hl_q [4];
  logic signed [HW+LW:0]   pp_lh_d [4];
  logic signed [HW+LW:0]   pp_lh_q [4];
  logic [2*LW-1:0]         pp_ll_d [4];
  logic [2*LW-1:0]         pp_ll_q [4];
  logic signed [PW-1:0]    prod_d  [4];
  logic signed [PW-1:0]    prod_q  [4];
  logic signed [SW-1:0]    sum_d;
  logic signed [SW-1:0]    sum_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pp_hh_d[k] = $signed(a_i[k][DATA_WIDTH-1:LW]) * $signed(b_i[k][DATA_WIDTH-1:LW]);
      pp_hl_d[k] = $signed(a_i[k][DATA_WIDTH-1:LW]) * $signed({1'b0, b_i[k][LW-1:0]});
      pp_lh_d[k] = $signed({1'b0, a_i[k][LW-1:0]}) * $signed(b_i[k][DATA_WIDTH-1:LW]);
      pp_ll_d[k] = a_i[k][LW-1:0] * b_i[k][LW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[k] = (PW'(pp_hh_q[k]) <<< (2 * LW))
                + ((PW'(pp_hl_q[k]) + PW'(pp_lh_q[k])) <<< LW)
                + PW'(pp_ll_q[k]);
    end
  end

  always_comb begin
    sum_d = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_hh_q <= pp_hh_d;
      pp_hl_q <= pp_hl_d;
      pp_lh_q <= pp_lh_d;
      pp_ll_q <= pp_ll_d;
      prod_q  <= prod_d;
      sum_q   <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- design/mm4_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_merge
// Scales the four lane sums back to Q format, saturates each column and
// combines the clip indications into one flag.
// ----------------------------------------------------------------------------
module mm4_merge #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic signed [2*DATA_WIDTH+1:0]     sum_i  [4],
  output logic signed [mm4_pkg::ELEM_W-1:0]  prod_o [4],
  output logic                               sat_o
);

  localparam int unsigned SW = 2 * DATA_WIDTH + 2;
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [SW-1:0]         shifted [4];
  logic [SW-DATA_WIDTH:0]       top_bits [4];
  logic                         fits [4];
  logic signed [DATA_WIDTH-1:0] res [4];

  always_comb begin
    sat_o = 1'b0;
    for (int c = 0; c < 4; c++) begin
      shifted[c]  = sum_i[c] >>> FRAC_BITS;
      top_bits[c] = shifted[c][SW-1:DATA_WIDTH-1];
      fits[c]     = (&top_bits[c]) || !(|top_bits[c]);
      if (fits[c]) begin
        res[c] = shifted[c][DATA_WIDTH-1:0];
      end else if (shifted[c][SW-1]) begin
        res[c] = MINV;
      end else begin
        res[c] = MAXV;
      end
      sat_o     = sat_o | !fits[c];
      prod_o[c] = mm4_pkg::ELEM_W'(res[c]);
    end
  end

endmodule

// ----- design/matrix_multiply_4x4_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit
// Streaming 4x4 fixed-point matrix multiply, one product row per transfer.
// ----------------------------------------------------------------------------
// The unit holds the right-hand matrix, reset to identity. A store transfer
// writes one of its rows and returns nothing; a multiply transfer carries a row
// of the left-hand matrix and returns the matching product row, saturated, with
// a flag when any column was clipped. One row is accepted every clock while
// the output is not stalled. The first of the three lane stages (split
// partial products, product assembly, column sum) loads at the transfer edge,
// and the output register after saturation follows the column sum stage.
// A store takes effect for the very next multiply. Output stalls hold the
// whole pipeline.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm4_in_if.sink     in_i,
  mm4_out_if.source  out_o
);

  localparam int unsigned SW = 2 * DATA_WIDTH + 2;
  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] ID_DIAG = ONE64[DATA_WIDTH-1:0];

  logic [DATA_WIDTH-1:0]             b_q [16];
  logic signed [DATA_WIDTH-1:0]      elem [4];
  logic signed [DATA_WIDTH-1:0]      col_b [4][4];
  logic signed [SW-1:0]              sums [4];
  logic signed [mm4_pkg::ELEM_W-1:0] prods [4];
  logic                              sat;
  logic                              en;
  logic                              in_xfer;
  logic [2:0]                        vld_q;
  logic [mm4_pkg::ROW_W-1:0]         row_q [3];
  logic                              out_valid_q;
  mm4_pkg::out_item_t                out_data_q;

  assign en      = !out_valid_q || out_o.ready;
  assign in_xfer = in_i.valid && en;
  assign in_i.ready = en;

  assign elem[0] = DATA_WIDTH'(in_i.data.elem0);
  assign elem[1] = DATA_WIDTH'(in_i.data.elem1);
  assign elem[2] = DATA_WIDTH'(in_i.data.elem2);
  assign elem[3] = DATA_WIDTH'(in_i.data.elem3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        b_q[i] <= (i % 5 == 0) ? ID_DIAG : '0;
      end
    end else if (in_xfer && in_i.data.kind == mm4_pkg::KIND_STORE) begin
      for (int r = 0; r < 4; r++) begin
        if (in_i.data.row_index == mm4_pkg::ROW_W'(r)) begin
          for (int k = 0; k < 4; k++) begin
            b_q[r*4+k] <= elem[k];
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        col_b[c][k] = b_q[k*4+c];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    mm4_lane #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (elem),
      .b_i   (col_b[c]),
      .sum_o (sums[c])
    );
  end

  mm4_merge #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .sum_i  (sums),
    .prod_o (prods),
    .sat_o  (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[1:0], in_xfer && in_i.data.kind == mm4_pkg::KIND_MULT};
      out_valid_q <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_q[0]             <= in_i.data.row_index;
      row_q[1]             <= row_q[0];
      row_q[2]             <= row_q[1];
      out_data_q.out_row   <= row_q[2];
      out_data_q.prod0     <= prods[0];
      out_data_q.prod1     <= prods[1];
      out_data_q.prod2     <= prods[2];
      out_data_q.prod3     <= prods[3];
      out_data_q.saturated <= sat;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_store_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.data.kind == mm4_pkg::KIND_STORE) |=> !vld_q[0])
    else $error("store transfer entered the multiply pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(vld_q) && out_valid_q))
    else $error("pipeline moved while the output was stalled");

  a_last_stage_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && en) |=> out_valid_q)
    else $error("finished row did not reach the output register");

endmodule

// ----- verif/matrix_multiply_4x4_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_unit_tb
// Self-checking bench for the streaming 4x4 Q16.16 matrix multiply unit.
// ----------------------------------------------------------------------------
// A queue of input rows is filled up front. It holds a short directed set of
// extreme values, saturation in both directions, and stores and multiplies on
// every row index. A long random mix follows, mostly whole right-hand matrix
// loads followed by multiply rows, with single stores and multiplies in
// between. A clocked driver sends the rows with random gaps. It keeps its own
// copy of the right-hand matrix and computes the expected product row for
// every multiply transfer. A clocked monitor stalls at random and compares
// each product row field by field with the oldest expected row. One long
// output hold fills the pipeline, and the sender pauses before chosen rows
// until every product row has come back.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_unit_tb;

  localparam int DW          = 32;
  localparam int FB          = 16;
  localparam int AW          = 2 * DW + 4;
  localparam int RAND_ROWS   = 1800;
  localparam int QUIET_ROWS  = 300;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER  = 200;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic signed [mm4_pkg::ELEM_W-1:0] E_MAX = 32'sh7fff_ffff;
  localparam logic signed [mm4_pkg::ELEM_W-1:0] E_MIN = 32'sh8000_0000;
  localparam logic signed [mm4_pkg::ELEM_W-1:0] E_ONE = 32'sh0001_0000;
  localparam logic signed [mm4_pkg::ELEM_W-1:0] E_NEG_ONE = -32'sh0001_0000;

  typedef struct {
    mm4_pkg::in_item_t row;
    bit                drain_first;
  } pending_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mm4_in_if  in_if ();
  mm4_out_if out_if ();

  matrix_multiply_4x4_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pending_row_t                      pending_rows[$];
  mm4_pkg::out_item_t                expected_rows[$];
  logic signed [mm4_pkg::ELEM_W-1:0] b_rows[4][4];
  int                                rows_sent = 0;
  int                                rows_checked = 0;
  int                                quiet_from;
  int                                mismatches = 0;
  int                                send_gap;
  int                                stall_left;
  int                                hold_left;
  bit                                hold_done;
  int                                idle_cycles;
  mm4_pkg::out_item_t                want_row;
  mm4_pkg::out_item_t                got_row;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic mm4_pkg::out_item_t product_row(mm4_pkg::in_item_t r);
    logic signed [mm4_pkg::ELEM_W-1:0] a[4];
    logic signed [AW-1:0]              acc;
    logic signed [AW-1:0]              ea;
    logic signed [AW-1:0]              eb;
    logic signed [AW-1:0]              maxv;
    logic signed [AW-1:0]              minv;
    logic signed [mm4_pkg::ELEM_W-1:0] col[4];
    mm4_pkg::out_item_t                res;
    a = '{r.elem0, r.elem1, r.elem2, r.elem3};
    maxv = {{(AW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    minv = -maxv - 1;
    res = '0;
    res.out_row = r.row_index;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        ea = a[k];
        eb = b_rows[k][c];
        acc = acc + ea * eb;
      end
      acc = acc >>> FB;
      if (acc > maxv) begin
        acc = maxv;
        res.saturated = 1'b1;
      end else if (acc < minv) begin
        acc = minv;
        res.saturated = 1'b1;
      end
      col[c] = acc[mm4_pkg::ELEM_W-1:0];
    end
    res.prod0 = col[0];
    res.prod1 = col[1];
    res.prod2 = col[2];
    res.prod3 = col[3];
    return res;
  endfunction

  function automatic logic signed [mm4_pkg::ELEM_W-1:0] pick_elem();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0, 1: return raw;
      2: return {{12{raw[19]}}, raw[19:0]};
      3: return {{8{raw[23]}}, raw[23:0]};
      4: begin
        case ($urandom_range(0, 6))
          0: return E_MAX;
          1: return E_MIN;
          2: return '0;
          3: return -1;
          4: return E_ONE;
          5: return E_NEG_ONE;
          default: return 1;
        endcase
      end
      5, 6: return {{16{raw[15]}}, raw[15:0]};
      default: return {{4{raw[27]}}, raw[27:0]};
    endcase
  endfunction

  task automatic add_row(logic kind, logic [mm4_pkg::ROW_W-1:0] idx,
                         logic signed [mm4_pkg::ELEM_W-1:0] e0,
                         logic signed [mm4_pkg::ELEM_W-1:0] e1,
                         logic signed [mm4_pkg::ELEM_W-1:0] e2,
                         logic signed [mm4_pkg::ELEM_W-1:0] e3,
                         bit drain = 1'b0);
    pending_row_t p;
    p.row.kind      = kind;
    p.row.row_index = idx;
    p.row.elem0     = e0;
    p.row.elem1     = e1;
    p.row.elem2     = e2;
    p.row.elem3     = e3;
    p.drain_first   = drain;
    pending_rows.push_back(p);
  endtask

  task automatic add_random_row(logic kind, logic [mm4_pkg::ROW_W-1:0] idx,
                                bit drain = 1'b0);
    add_row(kind, idx, pick_elem(), pick_elem(), pick_elem(), pick_elem(), drain);
  endtask

  // Driver: presents pending rows and predicts the product of every multiply transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      send_gap    <= 0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          b_rows[r][c] = (r == c) ? E_ONE : '0;
        end
      end
    end else begin
      if (in_if.valid && in_if.ready) begin
        rows_sent = rows_sent + 1;
        if (in_if.data.kind == mm4_pkg::KIND_STORE) begin
          b_rows[in_if.data.row_index][0] = in_if.data.elem0;
          b_rows[in_if.data.row_index][1] = in_if.data.elem1;
          b_rows[in_if.data.row_index][2] = in_if.data.elem2;
          b_rows[in_if.data.row_index][3] = in_if.data.elem3;
        end else begin
          expected_rows.push_back(product_row(in_if.data));
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_rows.size() != 0 &&
                     !(pending_rows[0].drain_first && expected_rows.size() != 0)) begin
          in_if.data  <= pending_rows[0].row;
          in_if.valid <= 1'b1;
          void'(pending_rows.pop_front());
          if (rows_sent < quiet_from && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks product rows and stalls the output side in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        rows_checked = rows_checked + 1;
        got_row = out_if.data;
        if (expected_rows.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Unexpected product row: row %0d cols %0d %0d %0d %0d sat %0b",
                     got_row.out_row, got_row.prod0, got_row.prod1, got_row.prod2,
                     got_row.prod3, got_row.saturated);
          end
        end else begin
          want_row = expected_rows.pop_front();
          if (got_row.out_row !== want_row.out_row || got_row.prod0 !== want_row.prod0 ||
              got_row.prod1 !== want_row.prod1 || got_row.prod2 !== want_row.prod2 ||
              got_row.prod3 !== want_row.prod3 ||
              got_row.saturated !== want_row.saturated) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("Product row mismatch at %0t ns:", $realtime);
              $display("  expected row %0d cols %0d %0d %0d %0d sat %0b",
                       want_row.out_row, want_row.prod0, want_row.prod1,
                       want_row.prod2, want_row.prod3, want_row.saturated);
              $display("  actual   row %0d cols %0d %0d %0d %0d sat %0b",
                       got_row.out_row, got_row.prod0, got_row.prod1,
                       got_row.prod2, got_row.prod3, got_row.saturated);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (rows_sent < quiet_from && $urandom_range(0, 11) == 0) begin
        stall_left   <= $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (hold_left == 0);
      end
    end
  end

  // A single long output hold, so that the pipeline fills and the input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rows_checked >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("** matrix_multiply_4x4_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_mult;
    rst_ni = 1'b0;

    // The reset matrix is the identity, so these rows come back unchanged.
    add_row(mm4_pkg::KIND_MULT, 2'd0, E_MAX, E_MIN, '0, -1);
    add_row(mm4_pkg::KIND_MULT, 2'd1, 1, E_NEG_ONE, E_ONE, 32'sh5555_aaaa);
    add_random_row(mm4_pkg::KIND_MULT, 2'd2);
    add_random_row(mm4_pkg::KIND_MULT, 2'd3);
    // All-maximum right matrix drives every column of the all-maximum and all-minimum rows into saturation.
    for (int r = 0; r < 4; r++) begin
      add_row(mm4_pkg::KIND_STORE, r[1:0], E_MAX, E_MAX, E_MAX, E_MAX);
    end
    add_row(mm4_pkg::KIND_MULT, 2'd0, E_MAX, E_MAX, E_MAX, E_MAX);
    add_row(mm4_pkg::KIND_MULT, 2'd1, E_MIN, E_MIN, E_MIN, E_MIN);
    add_row(mm4_pkg::KIND_MULT, 2'd2, '0, '0, '0, '0);
    add_row(mm4_pkg::KIND_MULT, 2'd3, 1, '0, '0, '0);
    // All-minimum right matrix: the product of two minimums is the largest value.
    for (int r = 0; r < 4; r++) begin
      add_row(mm4_pkg::KIND_STORE, r[1:0], E_MIN, E_MIN, E_MIN, E_MIN);
    end
    add_row(mm4_pkg::KIND_MULT, 2'd0, E_MIN, E_MIN, E_MIN, E_MIN);
    add_row(mm4_pkg::KIND_MULT, 2'd1, E_MAX, '0, '0, '0);
    add_row(mm4_pkg::KIND_MULT, 2'd2, -1, -1, -1, -1);
    // Negated identity; a store right before a multiply must take effect at once.
    for (int r = 0; r < 4; r++) begin
      add_row(mm4_pkg::KIND_STORE, r[1:0], (r == 0) ? E_NEG_ONE : '0,
              (r == 1) ? E_NEG_ONE : '0, (r == 2) ? E_NEG_ONE : '0,
              (r == 3) ? E_NEG_ONE : '0);
    end
    add_row(mm4_pkg::KIND_MULT, 2'd3, E_MIN, E_MAX, -1, 1);

    // Random part: mostly whole matrix loads each followed by a run of multiplies.
    while (pending_rows.size() < RAND_ROWS + 25) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int r = 0; r < 4; r++) begin
          add_random_row(mm4_pkg::KIND_STORE, r[1:0], r == 0 && pending_rows.size() > 1000 &&
                         pending_rows.size() < 1010);
        end
        n_mult = $urandom_range(1, 8);
        for (int i = 0; i < n_mult; i++) begin
          add_random_row(mm4_pkg::KIND_MULT, 2'($urandom_range(0, 3)));
        end
      end else begin
        add_random_row(($urandom_range(0, 2) == 0) ? mm4_pkg::KIND_STORE : mm4_pkg::KIND_MULT,
                       2'($urandom_range(0, 3)));
      end
    end
    pending_rows[25].drain_first = 1'b1;
    quiet_from = pending_rows.size() - QUIET_ROWS;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_rows.size() != 0 || in_if.valid || expected_rows.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("** matrix_multiply_4x4_unit: PASSED **");
    end else begin
      $display("** matrix_multiply_4x4_unit: FAILED **");
    end
    $finish;
  end

endmodule
